FILE: src/acc_pkg.sv
package acc_pkg;

    localparam int CHAN_W   = 3;
    localparam int RAW_W    = 12;
    localparam int AMP_W    = 17;
    localparam int CHARGE_W = 32;
    localparam int GAIN_W   = 16;
    localparam int PMT_W    = 14;
    localparam int ADDR_W   = 6;
    localparam int WORD_W   = 64;

    // Nonlinearity correction datapath widths.
    localparam int C_W   = 20;
    localparam int X_W   = 21;
    localparam int H_W   = 40;
    localparam int P_W   = H_W + X_W;
    localparam int D_W   = 40;
    localparam int FRAC_Q30 = 30;

    // Charge datapath widths.
    localparam int SCALE_Q_W = 21;
    localparam int MAG_W     = 21;
    localparam int P1_W      = MAG_W + GAIN_W;
    localparam int N_W       = P1_W + GAIN_W;
    localparam int NR_W      = N_W + 1;
    localparam int DEN_W     = PMT_W + 8;

    // Rescale by 1/51200 = 1/(25 * 2**11): drop eleven bits, then multiply by
    // the rounded-up reciprocal of 25 in Q30. This is exact for inputs below 2**30.
    localparam int          SCALE_SH  = 11;
    localparam int          RECIP_SH  = 30;
    localparam int          RECIP_W   = 26;
    localparam logic [RECIP_W-1:0] RECIP_25 = 26'd42949673;
    localparam int          SCALE_N_W = C_W + 16 - SCALE_SH;
    localparam int          SCALE_M_W = SCALE_N_W + RECIP_W;

    localparam logic [1:0] STATUS_NORMAL     = 2'd0;
    localparam logic [1:0] STATUS_BAD        = 2'd1;
    localparam logic [1:0] STATUS_NONLIN     = 2'd2;
    localparam logic [1:0] STATUS_NORMAL_ALT = 2'd3;

    localparam logic [1:0] REASON_NONE   = 2'd0;
    localparam logic [1:0] REASON_BAD    = 2'd1;
    localparam logic [1:0] REASON_NO_PMT = 2'd2;
    localparam logic [1:0] REASON_NO_HIT = 2'd3;

    localparam logic signed [AMP_W-1:0] KNEE  = 17'sd19200;
    localparam logic signed [AMP_W-1:0] CLAMP = 17'sd51200;
    localparam logic [15:0]             CLAMP_U = 16'd51200;
    localparam logic [GAIN_W-1:0]       UNITY_GAIN = 16'd4096;

    localparam logic signed [H_W:0] ONE_Q30   = 41'sd1073741824;
    localparam logic signed [H_W:0] DEN_FLOOR = 41'sd268435456;

    localparam logic [CHARGE_W-1:0] CHARGE_MAX = 32'h7FFF_FFFF;
    localparam logic [CHARGE_W-1:0] CHARGE_MIN = 32'h8000_0000;

    typedef logic signed [H_W-1:0] coef_t;
    // Element 0 is the linear coefficient, element 3 the quartic one.
    typedef coef_t [3:0] coef_set_t;

    localparam coef_set_t STAGE1_K = {
        40'sd8386257964, -40'sd11647274208, 40'sd5940139822, -40'sd41972933
    };
    localparam coef_set_t STAGE2_K = {
        40'sd789207668, -40'sd1308272604, 40'sd728514886, 40'sd107901233
    };

    typedef struct packed {
        logic signed [AMP_W-1:0] amp;
        logic [1:0]              reason;
        logic                    nl;
        logic [GAIN_W-1:0]       ag;
        logic [GAIN_W-1:0]       eg;
        logic [PMT_W-1:0]        pg;
    } acc_side_t;

    typedef struct packed {
        logic signed [AMP_W-1:0] amp;
        logic [1:0]              reason;
        logic                    neg;
        logic                    ovf;
    } acc_fin_t;

endpackage

FILE: src/acc_divider.sv
module acc_divider
#(
    parameter int NUM_W = 50,
    parameter int DEN_W = 40,
    parameter int Q_W   = 20,
    parameter int SB_W  = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [SB_W-1:0]  side_in,
    output logic             out_valid,
    output logic [Q_W-1:0]   quot,
    output logic [SB_W-1:0]  side_out
);

    // The numerator must stay below den * 2**Q_W; one quotient bit per stage.
    localparam int W = (NUM_W > DEN_W + Q_W - 1) ? NUM_W : DEN_W + Q_W - 1;

    logic [W-1:0]     rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];
    logic [SB_W-1:0]  sb_reg  [Q_W];
    logic [Q_W-1:0]   vld_reg;

    genvar k;
    generate
        for (k = 0; k < Q_W; k++)
        begin : g_step
            localparam int B = Q_W - 1 - k;
            logic [W-1:0]     rem_in;
            logic [W-1:0]     trial;
            logic [W-1:0]     rem_next;
            logic [DEN_W-1:0] den_in;
            logic [Q_W-1:0]   q_in;
            logic [Q_W-1:0]   q_next;
            logic [SB_W-1:0]  sb_in;
            logic             v_in;
            logic             fits;

            if (k == 0)
            begin : g_first
                assign rem_in = W'(num);
                assign den_in = den;
                assign q_in   = '0;
                assign sb_in  = side_in;
                assign v_in   = in_valid;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign q_in   = q_reg[k-1];
                assign sb_in  = sb_reg[k-1];
                assign v_in   = vld_reg[k-1];
            end

            always_comb
            begin
                trial     = W'(den_in) << B;
                fits      = (rem_in >= trial);
                rem_next  = fits ? rem_in - trial : rem_in;
                q_next    = q_in;
                q_next[B] = fits;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                    q_reg[k]   <= q_next;
                    sb_reg[k]  <= sb_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[Q_W-1];
    assign quot      = q_reg[Q_W-1];
    assign side_out  = sb_reg[Q_W-1];

endmodule

FILE: src/acc_correct.sv
module acc_correct
    import acc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [C_W-1:0] c_in,
    input  acc_side_t      side_in,
    input  coef_set_t      coef,
    output logic           out_valid,
    output logic [C_W-1:0] c_out,
    output acc_side_t      side_out
);

    // Stage 0 takes the input, stages 1..8 run Horner as multiply / round-add
    // pairs, stage 9 forms the denominator; the divider follows.
    localparam int NS = 10;
    localparam int SB_W_C = $bits(acc_side_t);

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic [C_W-1:0]        c;
        acc_side_t             side;
    } nl_carry_t;

    nl_carry_t               carry_reg [NS];
    logic [NS-1:0]           vld_reg;
    logic signed [P_W-1:0]   p_reg  [4];
    logic signed [P_W-1:0]   p_next [4];
    logic signed [P_W-1:0]   rnd    [4];
    logic signed [P_W-1:0]   sh     [4];
    coef_t                   h_reg  [4];
    coef_t                   h_next [4];
    logic [D_W-1:0]          d_reg;
    logic [D_W-1:0]          d_next;
    logic signed [H_W:0]     d_raw;
    logic signed [X_W-1:0]   x_next;
    logic [SB_W_C-1:0]       div_side;

    always_comb
    begin
        x_next = $signed({1'b0, c_in}) - X_W'(KNEE);
        p_next[0] = $signed(coef[3]) * carry_reg[0].x;
        for (int j = 1; j < 4; j++)
        begin
            p_next[j] = h_reg[j-1] * carry_reg[2*j].x;
        end
        // Division by 65536 truncates toward zero, as the correction requires.
        for (int j = 0; j < 4; j++)
        begin
            rnd[j] = p_reg[j] + (p_reg[j][P_W-1] ? P_W'(65535) : P_W'(0));
            sh[j]  = rnd[j] >>> 16;
        end
        for (int j = 0; j < 3; j++)
        begin
            h_next[j] = H_W'(sh[j]) + $signed(coef[2-j]);
        end
        h_next[3] = H_W'(sh[3]);
        d_raw  = ONE_Q30 - (H_W+1)'(h_reg[3]);
        d_next = (d_raw < DEN_FLOOR) ? D_W'(DEN_FLOOR) : D_W'(d_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            carry_reg[0].x    <= x_next;
            carry_reg[0].c    <= c_in;
            carry_reg[0].side <= side_in;
            for (int s = 1; s < NS; s++)
            begin
                carry_reg[s] <= carry_reg[s-1];
            end
            for (int j = 0; j < 4; j++)
            begin
                p_reg[j] <= p_next[j];
                h_reg[j] <= h_next[j];
            end
            d_reg <= d_next;
        end
    end

    acc_divider
    #(
        .NUM_W (C_W + FRAC_Q30),
        .DEN_W (D_W),
        .Q_W   (C_W),
        .SB_W  (SB_W_C)
    )
    u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[NS-1]),
        .num       ({carry_reg[NS-1].c, {FRAC_Q30{1'b0}}}),
        .den       (d_reg),
        .side_in   (carry_reg[NS-1].side),
        .out_valid (out_valid),
        .quot      (c_out),
        .side_out  (div_side)
    );

    assign side_out = acc_side_t'(div_side);

endmodule

FILE: src/adc_charge_calibration.sv
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while the output register is full and m_tready is low.
// The depth is set by the two nonlinearity stages and the charge divider,
// each built on a bit-per-stage divider.
// Reset (rst_n low, asynchronous) empties the pipeline and clears all calibration words.
module adc_charge_calibration
    import acc_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [11:0] raw_sample
    input  logic [2:0]        s_tuser,   // [2:0] channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,   // [16:0] amplitude, [48:17] charge
    output logic [2:0]        m_tuser,   // [1:0] zero_reason, [2] saturated
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int FIN_W = $bits(acc_fin_t);

    logic [WORD_W-1:0] calib_reg [NUM_CHANNELS];
    logic [CHAN_W-1:0] reg_idx;
    logic              reg_ok;
    logic              en;

    // Configuration port.
    assign reg_idx = paddr[ADDR_W-1:3];
    assign reg_ok  = (32'(reg_idx) < NUM_CHANNELS);
    assign pready  = 1'b1;
    assign prdata  = reg_ok ? calib_reg[reg_idx[IDX_W-1:0]] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                calib_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite && reg_ok)
        begin
            calib_reg[reg_idx[IDX_W-1:0]] <= pwdata;
        end
    end

    // Input register.
    logic              in_vld_reg;
    logic [CHAN_W-1:0] in_chan_reg;
    logic [RAW_W-1:0]  in_raw_reg;

    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_chan_reg <= s_tuser;
            in_raw_reg  <= s_tdata[RAW_W-1:0];
        end
    end

    // Decode the calibration word and decide the zero cases.
    logic [WORD_W-1:0]       word;
    logic [15:0]             ped;
    logic [1:0]              status;
    acc_side_t               side1_next;
    acc_side_t               side1_reg;
    logic [15:0]             c0_next;
    logic [15:0]             c0_reg;
    logic                    vld1_reg;

    always_comb
    begin
        word   = (32'(in_chan_reg) < NUM_CHANNELS) ? calib_reg[in_chan_reg[IDX_W-1:0]] : '0;
        ped    = word[15:0];
        status = word[63:62];
        side1_next.amp = $signed({1'b0, in_raw_reg, 4'b0000}) - $signed({1'b0, ped});
        side1_next.ag  = word[31:16];
        side1_next.eg  = (word[47:32] == '0) ? UNITY_GAIN : word[47:32];
        side1_next.pg  = word[61:48];
        if (status == STATUS_BAD)
        begin
            side1_next.reason = REASON_BAD;
        end
        else if (side1_next.pg == '0)
        begin
            side1_next.reason = REASON_NO_PMT;
        end
        else if (status == STATUS_NONLIN || side1_next.amp > 17'sd0)
        begin
            side1_next.reason = REASON_NONE;
        end
        else
        begin
            side1_next.reason = REASON_NO_HIT;
        end
        side1_next.nl = (status == STATUS_NONLIN) && (side1_next.amp > KNEE);
        c0_next = (side1_next.amp > CLAMP) ? CLAMP_U : side1_next.amp[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            c0_reg    <= c0_next;
        end
    end

    // Two correction stages.
    logic           vld_c1;
    logic [C_W-1:0] c1;
    acc_side_t      side_c1;
    logic           vld_c2;
    logic [C_W-1:0] c2;
    acc_side_t      side_c2;

    acc_correct u_corr1
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld1_reg),
        .c_in      (C_W'(c0_reg)),
        .side_in   (side1_reg),
        .coef      (STAGE1_K),
        .out_valid (vld_c1),
        .c_out     (c1),
        .side_out  (side_c1)
    );

    acc_correct u_corr2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_c1),
        .c_in      (c1),
        .side_in   (side_c1),
        .coef      (STAGE2_K),
        .out_valid (vld_c2),
        .c_out     (c2),
        .side_out  (side_c2)
    );

    // Rescale above the clamp: amp * c / 51200. Below it, c * 51200 / 51200 passes c.
    logic [15:0]         sc_fac;
    logic [C_W+15:0]     sc_prod_next;
    logic [C_W+15:0]     sc_prod_reg;
    acc_side_t           sc_side_reg;
    logic                sc_vld_reg;

    always_comb
    begin
        sc_fac       = (side_c2.amp > CLAMP) ? side_c2.amp[15:0] : CLAMP_U;
        sc_prod_next = c2 * sc_fac;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sc_vld_reg <= vld_c2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_prod_reg <= sc_prod_next;
            sc_side_reg <= side_c2;
        end
    end

    // The division by 51200 is a shift by eleven and a multiply by the
    // reciprocal of 25; the quotient is the top bits of the product.
    logic                 vld_sc;
    logic [SCALE_Q_W-1:0] sc_q;
    logic [SCALE_M_W-1:0] sm_next;
    logic [SCALE_M_W-1:0] sm_reg;
    acc_side_t            sm_side_reg;
    logic                 sm_vld_reg;
    acc_side_t            side3_in;

    always_comb
    begin
        sm_next = sc_prod_reg[C_W+15:SCALE_SH] * RECIP_25;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sm_vld_reg <= sc_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm_reg      <= sm_next;
            sm_side_reg <= sc_side_reg;
        end
    end

    assign vld_sc   = sm_vld_reg;
    assign sc_q     = sm_reg[RECIP_SH +: SCALE_Q_W];
    assign side3_in = sm_side_reg;

    // Magnitude, then the two gain products.
    logic [AMP_W-1:0] amp_abs;
    logic [MAG_W-1:0] mag_next;
    logic [MAG_W-1:0] mag_reg;
    logic             neg_next;
    logic             neg3_reg;
    logic             neg4_reg;
    logic             neg5_reg;
    acc_side_t        side3_reg;
    acc_side_t        side4_reg;
    acc_side_t        side5_reg;
    logic             vld3_reg;
    logic             vld4_reg;
    logic             vld5_reg;
    logic [P1_W-1:0]  p1_reg;
    logic [N_W-1:0]   n_reg;

    always_comb
    begin
        amp_abs = side3_in.amp[AMP_W-1] ? AMP_W'(-side3_in.amp) : AMP_W'(side3_in.amp);
        if (side3_in.nl)
        begin
            mag_next = sc_q;
            neg_next = 1'b0;
        end
        else
        begin
            mag_next = MAG_W'(amp_abs);
            neg_next = side3_in.amp[AMP_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else if (en)
        begin
            vld3_reg <= vld_sc;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_next;
            neg3_reg  <= neg_next;
            side3_reg <= side3_in;
            p1_reg    <= mag_reg * side3_reg.ag;
            neg4_reg  <= neg3_reg;
            side4_reg <= side3_reg;
            n_reg     <= p1_reg * side4_reg.eg;
            neg5_reg  <= neg4_reg;
            side5_reg <= side4_reg;
        end
    end

    // Add half the divisor for rounding; a quotient of 2**32 or more saturates anyway.
    logic [NR_W-1:0]  nr_next;
    logic [NR_W-1:0]  nr_reg;
    logic             ovf_next;
    acc_fin_t         fin6_reg;
    logic [PMT_W-1:0] pg6_reg;
    logic             vld6_reg;

    always_comb
    begin
        nr_next  = NR_W'(n_reg) + NR_W'({side5_reg.pg, 7'b0000000});
        ovf_next = (nr_next[NR_W-1:40] >= side5_reg.pg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld6_reg <= 1'b0;
        end
        else if (en)
        begin
            vld6_reg <= vld5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nr_reg          <= ovf_next ? '0 : nr_next;
            pg6_reg         <= side5_reg.pg;
            fin6_reg.amp    <= side5_reg.amp;
            fin6_reg.reason <= side5_reg.reason;
            fin6_reg.neg    <= neg5_reg;
            fin6_reg.ovf    <= ovf_next;
        end
    end

    logic                vld_fd;
    logic [CHARGE_W-1:0] fd_q;
    logic [FIN_W-1:0]    fd_side;
    acc_fin_t            fin;

    acc_divider
    #(
        .NUM_W (NR_W),
        .DEN_W (DEN_W),
        .Q_W   (CHARGE_W),
        .SB_W  (FIN_W)
    )
    u_charge_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld6_reg),
        .num       (nr_reg),
        .den       ({pg6_reg, 8'h00}),
        .side_in   (fin6_reg),
        .out_valid (vld_fd),
        .quot      (fd_q),
        .side_out  (fd_side)
    );

    assign fin = acc_fin_t'(fd_side);

    // Output register.
    logic [CHARGE_W-1:0] charge_next;
    logic                sat_next;
    logic [55:0]         m_tdata_reg;
    logic [2:0]          m_tuser_reg;

    always_comb
    begin
        charge_next = '0;
        sat_next    = 1'b0;
        if (fin.reason != REASON_NONE)
        begin
            charge_next = '0;
            sat_next    = 1'b0;
        end
        else if (!fin.neg)
        begin
            if (fin.ovf || fd_q[CHARGE_W-1])
            begin
                charge_next = CHARGE_MAX;
                sat_next    = 1'b1;
            end
            else
            begin
                charge_next = fd_q;
            end
        end
        else
        begin
            if (fin.ovf || (fd_q[CHARGE_W-1] && (fd_q[CHARGE_W-2:0] != '0)))
            begin
                charge_next = CHARGE_MIN;
                sat_next    = 1'b1;
            end
            else
            begin
                charge_next = CHARGE_W'(-fd_q);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= vld_fd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_fd)
        begin
            m_tdata_reg <= {7'b0000000, charge_next, fin.amp};
            m_tuser_reg <= {sat_next, fin.reason};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: src/acc_checker.sv
module acc_checker
    import acc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [2:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_zero_charge: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] != REASON_NONE) |-> (m_tdata[48:17] == '0) && !m_tuser[2])
        else $error("zeroed result carries a charge or saturation");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |->
            (m_tdata[48:17] == CHARGE_MAX) || (m_tdata[48:17] == CHARGE_MIN))
        else $error("saturated charge is not a range limit");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

endmodule

bind adc_charge_calibration acc_checker u_acc_checker (.*);
